@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the queue admission RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define BQA_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define BQA_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/core/bqa_pkg.sv @@
// ---------------------------------------------------------------------------
// BLUE queue admission package
// Payload types, codes and constants shared by the admission RTL.
// ---------------------------------------------------------------------------
package bqa_pkg;

  // Field widths
  localparam int RndW    = 31;
  localparam int DivCntW = $clog2(RndW);
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 31;

  // Queue capacity and time constants
  localparam logic [11:0] MaxQueue   = 12'd4095;
  localparam int          UsecPerSec = 1000000;
  localparam int          SecClamp   = 2200;
  localparam logic [33:0] ElapsedMax = 34'h0_7fff_ffff;

  // Opcodes
  localparam logic [1:0] OpEnqueue = 2'd0;
  localparam logic [1:0] OpDequeue = 2'd1;
  localparam logic [1:0] OpFlush   = 2'd2;
  localparam logic [1:0] OpIgnore  = 2'd3;

  // Address families
  localparam logic [1:0] FamV4 = 2'd0;
  localparam logic [1:0] FamV6 = 2'd1;

  // Verdicts
  localparam logic [2:0] VerQueued  = 3'd0;
  localparam logic [2:0] VerEarly   = 3'd1;
  localparam logic [2:0] VerForced  = 3'd2;
  localparam logic [2:0] VerDequeue = 3'd3;
  localparam logic [2:0] VerEmpty   = 3'd4;
  localparam logic [2:0] VerFlushed = 3'd5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgQueueLimit = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxPmark   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgHoldTime   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgEcnV4      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgEcnV6      = 3'd4;

  // TOS bits
  localparam logic [7:0] TosCe = 8'h01;

  typedef struct packed {
    logic [1:0]      opcode;
    logic [31:0]     now_sec;
    logic [19:0]     now_usec;
    logic [RndW-1:0] random_value;
    logic [1:0]      family;
    logic [7:0]      tos;
    logic [15:0]     header_checksum;
  } req_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic        ecn_marked;
    logic [7:0]  new_tos;
    logic [15:0] new_checksum;
    logic [11:0] queue_length;
    logic [15:0] mark_probability;
  } rsp_t;

endpackage

@@ rtl/core/bqa_if.sv @@
// ---------------------------------------------------------------------------
// BLUE queue admission channels
// Valid/ready request and response channels with their payload.
// ---------------------------------------------------------------------------
interface bqa_req_if import bqa_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bqa_rsp_if import bqa_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/blue_queue_admission.sv @@
// ---------------------------------------------------------------------------
// BLUE queue admission
// Admission decisions, ECN marking and mark probability for one queue.
// ---------------------------------------------------------------------------
// Usage:
//   req_if carries one request per handshake: enqueue, dequeue, flush or a
//   no-op code that is taken and answered with nothing. rsp_if returns one
//   response per enqueue, dequeue or flush request, in request order.
//   The cfg port writes one register per cycle; the user must write only while the block is idle (not enforced).
// Timing:
//   An enqueue passes from accept to response valid through these steps:
//   the second difference and its scaled product, the elapsed time
//   compare and idle update, the bit-serial remainder unit (random_value
//   mod max_pmark, one bit per cycle), and the decision. Dequeue and flush
//   go from accept straight to the decision step. req_if.ready is high
//   only between requests, so a new request is taken only once the
//   previous one has reached its decision.
// Reset:
//   Control, state and configuration registers return to their reset values,
//   the queue is empty and idle, and no response is pending.
// Stall:
//   A response waits in the output register; the block takes the next
//   request meanwhile and holds its own decision until the register frees.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module blue_queue_admission import bqa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  bqa_req_if.sink            req_if,
  bqa_rsp_if.source          rsp_if
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TIME = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  // Configuration
  logic [11:0] queue_limit_q;
  logic [15:0] max_pmark_q;
  logic [30:0] hold_time_q;
  logic        ecn_v4_q;
  logic        ecn_v6_q;

  // Block state
  logic [2:0]  state_q, state_d;
  logic [15:0] mark_prob_q, mark_prob_d;
  logic        idle_q, idle_d;
  logic [31:0] last_sec_q, last_sec_d;
  logic [19:0] last_usec_q, last_usec_d;
  logic [11:0] qcount_q, qcount_d;

  // Per-request working registers
  req_t               item_q;
  logic               sd_gt1_q;
  logic signed [33:0] prod_q;
  logic               el_gt_q, el_gt_d;
  logic               stamped_q, stamped_d;
  logic [15:0]        rem_q, rem_d;
  logic [RndW-1:0]    rnd_sh_q, rnd_sh_d;
  logic [DivCntW-1:0] div_cnt_q, div_cnt_d;

  // Output register
  rsp_t rsp_q, rsp_d;
  logic out_valid_q, out_valid_d;
  logic out_load;

  logic accept;
  assign accept        = req_if.valid && req_if.ready;
  assign req_if.ready  = (state_q == S_IDLE);
  assign rsp_if.valid  = out_valid_q;
  assign rsp_if.data   = rsp_q;

  // Second difference, clamped so the scaled product stays narrow
  logic signed [32:0] sec_diff;
  logic signed [12:0] sec_clamp;
  logic signed [21:0] usec_k;
  logic signed [33:0] prod_d;

  assign sec_diff = $signed({1'b0, item_q.now_sec}) - $signed({1'b0, last_sec_q});
  assign usec_k   = 22'(UsecPerSec);

  always_comb begin
    if (sec_diff > $signed(33'(SecClamp))) begin
      sec_clamp = 13'(SecClamp);
    end else if (sec_diff < -$signed(33'(SecClamp))) begin
      sec_clamp = -13'(SecClamp);
    end else begin
      sec_clamp = sec_diff[12:0];
    end
  end

  assign prod_d = sec_clamp * usec_k;

  // Elapsed microseconds, saturated, against the hold time
  logic signed [20:0] usec_diff;
  logic signed [33:0] elapsed;
  logic signed [33:0] elapsed_sat;
  logic               el_gt;

  assign usec_diff   = $signed({1'b0, item_q.now_usec}) - $signed({1'b0, last_usec_q});
  assign elapsed     = prod_q + 34'(usec_diff);
  assign elapsed_sat = (elapsed > $signed(ElapsedMax)) ? $signed(ElapsedMax) : elapsed;
  assign el_gt       = elapsed_sat > $signed({3'b000, hold_time_q});

  // Remainder step: shift in one bit, subtract when it fits
  logic [16:0] div_trial;
  logic        div_fits;

  assign div_trial = {rem_q, rnd_sh_q[RndW-1]};
  assign div_fits  = div_trial >= {1'b0, max_pmark_q};

  // Enqueue decision terms
  logic [RndW-1:0] rem_fin;
  logic            early_hit;
  logic            can_v4;
  logic            can_v6;
  logic            marked;
  logic            early;
  logic [11:0]     limit;
  logic [16:0]     prob_up;
  logic [15:0]     prob_cap;
  logic [17:0]     cs_sum0;
  logic [17:0]     cs_sum1;
  logic [17:0]     cs_sum2;
  logic [7:0]      ntos;
  logic [15:0]     ncsum;

  assign rem_fin   = (max_pmark_q == 16'd0) ? item_q.random_value : RndW'(rem_q);
  assign early_hit = (rem_fin < RndW'(mark_prob_q)) && (qcount_q > 12'd1);
  assign can_v4    = (item_q.family == FamV4) && ecn_v4_q && item_q.tos[1];
  assign can_v6    = (item_q.family == FamV6) && ecn_v6_q && item_q.tos[1];
  assign marked    = early_hit && (can_v4 || can_v6);
  assign early     = early_hit && !marked;
  assign limit     = (queue_limit_q < MaxQueue) ? queue_limit_q : MaxQueue;
  assign prob_up   = 17'(mark_prob_q) + 17'(max_pmark_q >> 3);
  assign prob_cap  = (prob_up > 17'(max_pmark_q)) ? max_pmark_q : prob_up[15:0];

  // Incremental checksum update for setting the CE bit
  assign cs_sum0 = {2'b00, ~item_q.header_checksum} + 18'(16'hffff) + 18'(TosCe);
  assign cs_sum1 = 18'(cs_sum0[17:16]) + 18'(cs_sum0[15:0]);
  assign cs_sum2 = cs_sum1 + 18'(cs_sum1[17:16]);

  always_comb begin
    ntos  = item_q.tos;
    ncsum = item_q.header_checksum;
    if (early_hit && can_v4) begin
      if ((item_q.tos & TosCe) == 8'h00) begin
        ntos  = item_q.tos | TosCe;
        ncsum = ~cs_sum2[15:0];
      end
    end else if (early_hit && can_v6) begin
      ntos = item_q.tos | TosCe;
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    mark_prob_d = mark_prob_q;
    idle_d      = idle_q;
    last_sec_d  = last_sec_q;
    last_usec_d = last_usec_q;
    qcount_d    = qcount_q;
    el_gt_d     = el_gt_q;
    stamped_d   = stamped_q;
    rem_d       = rem_q;
    rnd_sh_d    = rnd_sh_q;
    div_cnt_d   = div_cnt_q;
    rsp_d       = rsp_q;
    out_valid_d = out_valid_q;
    out_load    = 1'b0;

    // Release the response once taken
    if (out_valid_q && rsp_if.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_if.data.opcode)
            OpEnqueue: state_d = S_TIME;
            OpDequeue: state_d = S_FIN;
            OpFlush:   state_d = S_FIN;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_TIME: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        // Idle update, then arm the remainder unit
        el_gt_d   = el_gt;
        stamped_d = 1'b0;
        if (idle_q) begin
          idle_d = 1'b0;
          if (sd_gt1_q) begin
            mark_prob_d = 16'd1;
            stamped_d   = 1'b1;
          end else if (el_gt) begin
            if (mark_prob_q != 16'd0) begin
              mark_prob_d = mark_prob_q - 16'd1;
            end
            stamped_d = 1'b1;
          end
        end
        if (stamped_d) begin
          last_sec_d  = item_q.now_sec;
          last_usec_d = item_q.now_usec;
        end
        rem_d     = 16'd0;
        rnd_sh_d  = item_q.random_value;
        div_cnt_d = DivCntW'(RndW - 1);
        state_d   = S_DIV;
      end
      S_DIV: begin
        rem_d     = div_fits ? 16'(div_trial - {1'b0, max_pmark_q}) : div_trial[15:0];
        rnd_sh_d  = {rnd_sh_q[RndW-2:0], 1'b0};
        div_cnt_d = div_cnt_q - DivCntW'(1);
        if (div_cnt_q == '0) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        // Decide once the output register is free
        if (!out_valid_q || rsp_if.ready) begin
          out_load         = 1'b1;
          rsp_d            = '0;
          case (item_q.opcode)
            OpEnqueue: begin
              rsp_d.ecn_marked   = marked;
              rsp_d.new_tos      = ntos;
              rsp_d.new_checksum = ncsum;
              if (early) begin
                rsp_d.verdict = VerEarly;
              end else if (qcount_q >= limit) begin
                rsp_d.verdict = VerForced;
                if (el_gt_q && !stamped_q) begin
                  mark_prob_d = prob_cap;
                  last_sec_d  = item_q.now_sec;
                  last_usec_d = item_q.now_usec;
                end
              end else begin
                rsp_d.verdict = VerQueued;
                qcount_d      = qcount_q + 12'd1;
              end
            end
            OpDequeue: begin
              if (qcount_q == 12'd0) begin
                rsp_d.verdict = VerEmpty;
                if (!idle_q) begin
                  idle_d      = 1'b1;
                  last_sec_d  = item_q.now_sec;
                  last_usec_d = item_q.now_usec;
                end
              end else begin
                rsp_d.verdict = VerDequeue;
                qcount_d      = qcount_q - 12'd1;
                idle_d        = 1'b0;
              end
            end
            default: begin
              rsp_d.verdict = VerFlushed;
              qcount_d      = 12'd0;
            end
          endcase
          rsp_d.queue_length     = qcount_d;
          rsp_d.mark_probability = mark_prob_d;
          out_valid_d            = 1'b1;
          state_d                = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and block state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mark_prob_q <= 16'd0;
      idle_q      <= 1'b1;
      last_sec_q  <= 32'd0;
      last_usec_q <= 20'd0;
      qcount_q    <= 12'd0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      mark_prob_q <= mark_prob_d;
      idle_q      <= idle_d;
      last_sec_q  <= last_sec_d;
      last_usec_q <= last_usec_d;
      qcount_q    <= qcount_d;
      out_valid_q <= out_valid_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_limit_q <= 12'd200;
      max_pmark_q   <= 16'd1000;
      hold_time_q   <= 31'd50000;
      ecn_v4_q      <= 1'b0;
      ecn_v6_q      <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgQueueLimit: queue_limit_q <= cfg_data_i[11:0];
        CfgMaxPmark:   max_pmark_q   <= cfg_data_i[15:0];
        CfgHoldTime:   hold_time_q   <= cfg_data_i[30:0];
        CfgEcnV4:      ecn_v4_q      <= cfg_data_i[0];
        CfgEcnV6:      ecn_v6_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Payload and working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= req_if.data;
    end
    if (state_q == S_TIME) begin
      prod_q   <= prod_d;
      sd_gt1_q <= (sec_diff > 33'sd1);
    end
    el_gt_q   <= el_gt_d;
    stamped_q <= stamped_d;
    rem_q     <= rem_d;
    rnd_sh_q  <= rnd_sh_d;
    if (out_load) begin
      rsp_q <= rsp_d;
    end
  end

  // Assertions
  `BQA_ASSERT_IMP(a_rem_bound, clk_i, rst_ni,
    (state_q == S_DIV) && (max_pmark_q != 16'd0), rem_q < max_pmark_q,
    "partial remainder reached the modulus")
  `BQA_ASSERT_NXT(a_noop_silent, clk_i, rst_ni,
    accept && (req_if.data.opcode == OpIgnore),
    (state_q == S_IDLE) && !$rose(out_valid_q),
    "no-op request produced work or a response")
  `BQA_ASSERT_IMP(a_rsp_from_fin, clk_i, rst_ni,
    $rose(out_valid_q), $past(state_q) == S_FIN,
    "response raised outside the decision step")

endmodule

@@ dv/tb_blue_queue_admission.sv @@
// ---------------------------------------------------------------------------
// BLUE queue admission testbench
// Drives enqueue, dequeue, flush and no-op requests through the valid/ready
// request channel under several register settings. An internal predictor
// tracks mark probability, idle state, update time and queue length, and
// every response is compared field by field with the oldest expected one.
// ---------------------------------------------------------------------------
module tb_blue_queue_admission;
  import bqa_pkg::*;

  localparam logic [1:0] FamOther = 2'd2;
  localparam logic [7:0] TosEct   = 8'h02;
  localparam int         DrainCycles = 48;

  logic               clk_i  = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;

  bqa_req_if req_ch ();
  bqa_rsp_if rsp_ch ();

  blue_queue_admission dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_if     (req_ch),
    .rsp_if     (rsp_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor copy of the registers
  logic [11:0] limit_cfg = 12'd200;
  logic [15:0] pmax_cfg  = 16'd1000;
  logic [30:0] hold_cfg  = 31'd50000;
  logic        ecn4_cfg  = 1'b0;
  logic        ecn6_cfg  = 1'b0;

  // Predictor copy of the admission state
  logic [15:0] prob_q      = '0;
  logic        idle_q      = 1'b1;
  logic [31:0] stamp_sec   = '0;
  logic [19:0] stamp_usec  = '0;
  logic [11:0] backlog     = '0;

  req_t pending_requests[$];
  rsp_t expected_decisions[$];
  int   mismatches = 0;

  // Running packet clock for generated requests
  logic [31:0] clock_sec  = '0;
  logic [19:0] clock_usec = '0;

  int          burst_left;
  int          gap_left;
  logic [15:0] ready_bits;
  logic [3:0]  ready_pos;

  function automatic longint elapsed_us(logic [31:0] s, logic [19:0] us);
    longint e;
    e = (longint'({32'b0, s}) - longint'({32'b0, stamp_sec})) * 1000000 +
        (longint'({44'b0, us}) - longint'({44'b0, stamp_usec}));
    if (e > 64'sh7fff_ffff) e = 64'sh7fff_ffff;
    return e;
  endfunction

  // Incremental IPv4 checksum update for setting the CE bit
  function automatic logic [15:0] ce_checksum(logic [15:0] hc);
    logic [31:0] sum;
    sum = {16'b0, ~hc} + 32'h0000_ffff + 32'd1;
    sum = (sum >> 16) + (sum & 32'h0000_ffff);
    sum = sum + (sum >> 16);
    return ~sum[15:0];
  endfunction

  // Advance the predictor by one accepted request and queue its response (no-ops have none)
  function automatic void predict_admission(req_t r);
    rsp_t        res;
    logic [31:0] rem;
    logic [11:0] lim;
    logic [16:0] raised;
    logic        early_drop;
    logic        ecn_ok;
    if (r.opcode == OpIgnore) return;
    res = '0;
    if (r.opcode == OpEnqueue) begin
      res.new_tos = r.tos;
      res.new_checksum = r.header_checksum;
      early_drop = 1'b0;
      // Decay or restart the probability after an idle period
      if (idle_q) begin
        idle_q = 1'b0;
        if (longint'({32'b0, r.now_sec}) - longint'({32'b0, stamp_sec}) > 1) begin
          prob_q = 16'd1;
          stamp_sec = r.now_sec;
          stamp_usec = r.now_usec;
        end else if (elapsed_us(r.now_sec, r.now_usec) > longint'({33'b0, hold_cfg})) begin
          if (prob_q != 0) prob_q = prob_q - 1'b1;
          stamp_sec = r.now_sec;
          stamp_usec = r.now_usec;
        end
      end
      // Early mark or drop test
      rem = (pmax_cfg != 0) ? ({1'b0, r.random_value} % {16'b0, pmax_cfg})
                            : {1'b0, r.random_value};
      if (rem < {16'b0, prob_q} && backlog > 1) begin
        ecn_ok = 1'b0;
        if (r.family == FamV4 && ecn4_cfg && (r.tos & TosEct) != 0) begin
          ecn_ok = 1'b1;
          if ((r.tos & TosCe) == 0) begin
            res.new_tos = r.tos | TosCe;
            res.new_checksum = ce_checksum(r.header_checksum);
          end
        end else if (r.family == FamV6 && ecn6_cfg && (r.tos & TosEct) != 0) begin
          ecn_ok = 1'b1;
          res.new_tos = r.tos | TosCe;
        end
        if (ecn_ok) res.ecn_marked = 1'b1;
        else early_drop = 1'b1;
      end
      // Forced drop at the limit, else admit
      lim = (limit_cfg < MaxQueue) ? limit_cfg : MaxQueue;
      if (early_drop) begin
        res.verdict = VerEarly;
      end else if (backlog >= lim) begin
        res.verdict = VerForced;
        if (elapsed_us(r.now_sec, r.now_usec) > longint'({33'b0, hold_cfg})) begin
          raised = {1'b0, prob_q} + {4'b0, pmax_cfg[15:3]};
          if (raised > {1'b0, pmax_cfg}) raised = {1'b0, pmax_cfg};
          prob_q = raised[15:0];
          stamp_sec = r.now_sec;
          stamp_usec = r.now_usec;
        end
      end else begin
        res.verdict = VerQueued;
        backlog = backlog + 1'b1;
      end
    end else if (r.opcode == OpDequeue) begin
      if (backlog == 0) begin
        res.verdict = VerEmpty;
        if (!idle_q) begin
          idle_q = 1'b1;
          stamp_sec = r.now_sec;
          stamp_usec = r.now_usec;
        end
      end else begin
        res.verdict = VerDequeue;
        backlog = backlog - 1'b1;
        idle_q = 1'b0;
      end
    end else begin
      res.verdict = VerFlushed;
      backlog = '0;
    end
    res.queue_length = backlog;
    res.mark_probability = prob_q;
    expected_decisions.push_back(res);
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", name, want, got);
    end
  endtask

  task automatic check_response(rsp_t got);
    rsp_t want;
    if (expected_decisions.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected response %p", got);
    end else begin
      want = expected_decisions.pop_front();
      check_field("verdict", 32'(want.verdict), 32'(got.verdict));
      check_field("ecn_marked", 32'(want.ecn_marked), 32'(got.ecn_marked));
      check_field("new_tos", 32'(want.new_tos), 32'(got.new_tos));
      check_field("new_checksum", 32'(want.new_checksum), 32'(got.new_checksum));
      check_field("queue_length", 32'(want.queue_length), 32'(got.queue_length));
      check_field("mark_probability", 32'(want.mark_probability),
                  32'(got.mark_probability));
    end
  endtask

  // Request driver: bursts of requests with random gaps between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      burst_left = 1;
      gap_left = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) predict_admission(req_ch.data);
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          req_ch.data <= pending_requests.pop_front();
          req_ch.valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: check accepted responses, stall on a rotating mask
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      ready_bits <= 16'hffff;
      ready_pos <= '0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) check_response(rsp_ch.data);
      if (ready_pos == 4'd15) begin
        case ($urandom_range(0, 2))
          0: ready_bits <= 16'hffff;
          1: ready_bits <= 16'($urandom);
          default: ready_bits <= 16'($urandom & $urandom & $urandom);
        endcase
      end
      ready_pos <= ready_pos + 1'b1;
      rsp_ch.ready <= ready_bits[ready_pos];
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    case (idx)
      CfgQueueLimit: limit_cfg = value[11:0];
      CfgMaxPmark:   pmax_cfg = value[15:0];
      CfgHoldTime:   hold_cfg = value[30:0];
      CfgEcnV4:      ecn4_cfg = value[0];
      CfgEcnV6:      ecn6_cfg = value[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [11:0] lim, logic [15:0] pmax, logic [30:0] hold,
                           logic ecn4, logic ecn6);
    write_reg(CfgQueueLimit, CfgW'(lim));
    write_reg(CfgMaxPmark, CfgW'(pmax));
    write_reg(CfgHoldTime, CfgW'(hold));
    write_reg(CfgEcnV4, CfgW'(ecn4));
    write_reg(CfgEcnV6, CfgW'(ecn6));
  endtask

  // Wait until every request is taken and answered, then let the block settle
  task automatic settle();
    while (pending_requests.size() != 0 || req_ch.valid || expected_decisions.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic req_t make_request(logic [1:0] op, logic [31:0] sec, logic [19:0] usec,
                                        logic [30:0] rnd, logic [1:0] fam, logic [7:0] tos,
                                        logic [15:0] csum);
    req_t r;
    r.opcode = op;
    r.now_sec = sec;
    r.now_usec = usec;
    r.random_value = rnd;
    r.family = fam;
    r.tos = tos;
    r.header_checksum = csum;
    return r;
  endfunction

  // Move the packet clock: mostly small steps, sometimes jumps or steps back
  task automatic advance_clock();
    int unsigned       pick;
    longint unsigned   total;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      total = longint'(clock_usec) + $urandom_range(0, 200);
    end else if (pick < 80) begin
      total = longint'(clock_usec) + $urandom_range(0, 120000);
    end else if (pick < 90) begin
      total = longint'(clock_usec) + 64'd1000000 * $urandom_range(1, 4);
    end else if (pick < 95) begin
      clock_sec = clock_sec - $urandom_range(0, 1);
      total = $urandom_range(0, 999999);
    end else begin
      clock_sec = $urandom;
      total = $urandom_range(0, 999999);
    end
    clock_sec = clock_sec + 32'(total / 1000000);
    clock_usec = 20'(total % 1000000);
  endtask

  // Random traffic in blocks that fill, balance or drain the queue
  task automatic queue_random_phase(int unsigned count);
    int unsigned made;
    int unsigned block_left;
    int unsigned enq_share;
    int unsigned pick;
    req_t        r;
    made = 0;
    block_left = 0;
    enq_share = 50;
    while (made < count) begin
      if (block_left == 0) begin
        block_left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0: enq_share = 85;
          1: enq_share = 50;
          default: enq_share = 25;
        endcase
      end
      advance_clock();
      pick = $urandom_range(0, 999);
      r = make_request(OpEnqueue, clock_sec, clock_usec, 31'($urandom),
                       2'($urandom_range(0, 2)), 8'($urandom), 16'($urandom));
      if ($urandom_range(0, 1) == 0) r.tos = r.tos | TosEct;
      if (pick < 10) begin
        r.opcode = OpIgnore;
      end else begin
        if (pick < 30) r.opcode = OpFlush;
        else if (pick < 30 + enq_share * 97 / 10) r.opcode = OpEnqueue;
        else r.opcode = OpDequeue;
        made++;
        block_left--;
      end
      pending_requests.push_back(r);
    end
  endtask

  // Directed sequence under limit 3, max 8, hold 0, ECN on for both families
  task automatic queue_directed();
    int i;
    pending_requests.push_back(make_request(OpDequeue, 32'd0, 20'd0, 31'd0, FamV4, 8'h00, 16'h0));
    pending_requests.push_back(make_request(OpEnqueue, 32'd5, 20'd0, 31'd0, FamV4, 8'h00, 16'h0));
    pending_requests.push_back(make_request(OpEnqueue, 32'd5, 20'd1, 31'd7, FamV6, 8'h00, 16'h0));
    pending_requests.push_back(make_request(OpEnqueue, 32'd5, 20'd2, 31'd7, FamOther, 8'h00,
                                            16'h0));
    // Force drops at the limit until the probability reaches its ceiling
    for (i = 0; i < 7; i++)
      pending_requests.push_back(make_request(OpEnqueue, 32'd5, 20'(3 + i), 31'h7fff_ffff,
                                              FamV4, 8'h00, 16'h0));
    // Probability now at max: every test fires
    pending_requests.push_back(make_request(OpEnqueue, 32'd5, 20'd20, 31'd0, FamV4, 8'h02,
                                            16'h0000));
    pending_requests.push_back(make_request(OpEnqueue, 32'd5, 20'd21, 31'd1, FamV4, 8'h03,
                                            16'hffff));
    pending_requests.push_back(make_request(OpEnqueue, 32'd5, 20'd22, 31'd2, FamV6, 8'hfe,
                                            16'h1234));
    pending_requests.push_back(make_request(OpEnqueue, 32'd5, 20'd23, 31'd3, FamV6, 8'h01,
                                            16'h0));
    pending_requests.push_back(make_request(OpEnqueue, 32'd5, 20'd24, 31'd4, FamOther, 8'hff,
                                            16'hffff));
    pending_requests.push_back(make_request(OpEnqueue, 32'd5, 20'd25, 31'd5, FamV4, 8'h01,
                                            16'h8000));
    for (i = 0; i < 4; i++)
      pending_requests.push_back(make_request(OpDequeue, 32'd6, 20'(i), 31'd0, FamV4, 8'h00,
                                              16'h0));
    pending_requests.push_back(make_request(OpFlush, 32'd6, 20'd9, 31'd0, FamV4, 8'h00, 16'h0));
    pending_requests.push_back(make_request(OpIgnore, 32'd6, 20'd10, 31'd0, FamV4, 8'h00,
                                            16'h0));
    // Time running backwards after idle leaves the probability alone
    pending_requests.push_back(make_request(OpEnqueue, 32'd4, 20'd999999, 31'd0, FamV4, 8'h00,
                                            16'h0));
    pending_requests.push_back(make_request(OpDequeue, 32'd4, 20'd999999, 31'd0, FamV4, 8'h00,
                                            16'h0));
    pending_requests.push_back(make_request(OpDequeue, 32'd7, 20'd0, 31'd0, FamV4, 8'h00,
                                            16'h0));
    pending_requests.push_back(make_request(OpEnqueue, 32'hffff_ffff, 20'd999999,
                                            31'h7fff_ffff, FamV4, 8'hff, 16'hffff));
    clock_sec = 32'hffff_ffff;
    clock_usec = 20'd999999;
  endtask

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Reset, then run the phases with their register settings
  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_random_phase(150);
    settle();

    write_all(12'd3, 16'd8, 31'd0, 1'b1, 1'b1);
    queue_directed();
    settle();

    write_all(12'd4, 16'd16, 31'd0, 1'b1, 1'b1);
    queue_random_phase(250);
    settle();

    write_all(12'd4095, 16'd65535, 31'h7fff_ffff, 1'b0, 1'b0);
    queue_random_phase(150);
    settle();

    write_all(12'd1, 16'd1, 31'd100, 1'b1, 1'b0);
    queue_random_phase(150);
    settle();

    write_all(12'd8, 16'd0, 31'd10, 1'b0, 1'b1);
    queue_random_phase(150);
    settle();

    repeat (2) begin
      write_all(12'($urandom_range(2, 12)), 16'($urandom_range(1, 64)),
                31'($urandom_range(0, 5000)), 1'($urandom), 1'($urandom));
      queue_random_phase(175);
      settle();
    end

    if (mismatches == 0 && expected_decisions.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
